// ----- rtl/mwe_pkg.sv -----
// shared types and constants of the midi wire encoder
package mwe_pkg;

    // input item function codes
    localparam logic [2:0] FN_CHAN       = 3'd0;
    localparam logic [2:0] FN_SX_STATUS  = 3'd1;
    localparam logic [2:0] FN_SX_BODY    = 3'd2;
    localparam logic [2:0] FN_NOTES_OFF  = 3'd3;
    localparam logic [2:0] FN_RESET_CTRL = 3'd4;
    localparam logic [2:0] FN_REAPPLY    = 3'd5;

    // channel message kinds with special handling
    localparam logic [2:0] KD_CONTROL    = 3'd3;
    localparam logic [2:0] KD_PROGRAM    = 3'd4;
    localparam logic [2:0] KD_CHAN_PRESS = 3'd5;
    localparam logic [2:0] KD_IGNORED    = 3'd7;

    // controller numbers and volume values
    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
    localparam logic [6:0] CC_RESET_CTRL = 7'd121;
    localparam logic [6:0] VOL_DEFAULT   = 7'd100;
    localparam logic [6:0] VOL_MAX       = 7'd127;

    localparam logic [3:0] ST_CONTROL    = 4'hB;
    localparam logic [7:0] SYSEX_EOX     = 8'hF7;
    localparam logic [3:0] MASTER_RESET  = 4'd15;

    // 65535 / 15, reciprocal for the divide by 15
    localparam logic [12:0] DIV15_RECIP  = 13'd4369;

    localparam int CH_W   = 4;
    localparam int VOL_W  = 7;
    localparam int PROD_W = 11;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] kind;
        logic [3:0] channel;
        logic [6:0] param_first;
        logic [6:0] param_second;
        logic [7:0] data_byte;
        logic       sysex_end;
        logic       clear_volumes;
    } t_item;

    typedef struct packed {
        logic             en;
        logic             direct;
        logic [CH_W-1:0]  ch;
        logic [VOL_W-1:0] value;
    } t_vol_req;

    typedef struct packed {
        logic             en;
        logic [CH_W-1:0]  ch;
        logic [VOL_W-1:0] value;
    } t_vol_wr;

    typedef struct packed {
        logic       valid;
        logic [7:0] wire_byte;
        logic       last;
    } t_beat;

endpackage

// ----- rtl/mwe_in_if.sv -----
// input item channel of the midi wire encoder
interface mwe_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [2:0] kind;
    logic [3:0] channel;
    logic [6:0] param_first;
    logic [6:0] param_second;
    logic [7:0] data_byte;
    logic       sysex_end;
    logic       clear_volumes;

    modport source (
        output valid, func, kind, channel, param_first, param_second,
               data_byte, sysex_end, clear_volumes,
        input  ready
    );
    modport sink (
        input  valid, func, kind, channel, param_first, param_second,
               data_byte, sysex_end, clear_volumes,
        output ready
    );
endinterface

// ----- rtl/mwe_out_if.sv -----
// wire byte channel of the midi wire encoder
interface mwe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       last;

    modport source (output valid, wire_byte, last, input ready);
    modport sink (input valid, wire_byte, last, output ready);
endinterface

// ----- rtl/midi_wire_encoder_volume_scaled_top.sv -----
// top level of the midi wire encoder with master volume scaling
//
//  port    | dir | handshake      | payload
//  i_in    | in  | valid / ready  | func kind channel param_first param_second
//          |     |                | data_byte sysex_end clear_volumes
//  o_out   | out | valid / ready  | wire_byte last
//  apb     | in  | psel / penable | master_volume at byte address 0
//
// one wire byte per cycle unless the output stalls or a volume is awaited; a
// channel message is 1 to 3 bytes, a broadcast 3 per channel (48 for 16 channels).
// volume bytes come from a 3 stage path: ram read, multiply, divide by 15,
// which lines up with the status and controller bytes of the same group.
// reset clears the written flags of the volume store at once; no clearing pass.
// a stalled output register holds the sequencer; the next item is taken as
// soon as the last byte of the current one sits in the output register.
module midi_wire_encoder_volume_scaled_top #(
    parameter int CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwe_in_if.sink      i_in,
    mwe_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwe_pkg::*;

    localparam logic [1:0] ADDR_MASTER = 2'd0;

    logic [3:0]       r_master_vol;
    logic             cfg_wr;
    t_item            item;
    logic             accept;
    logic             seq_busy;
    logic             load_ok;
    t_beat            beat;
    t_vol_req         vol_req;
    t_vol_wr          vol_wr;
    logic             vol_clr;
    logic [VOL_W-1:0] vol_val;
    logic             vol_rdy;
    logic             vol_take;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MASTER);
    assign prdata = (paddr == ADDR_MASTER) ? {28'b0, r_master_vol} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_vol <= MASTER_RESET;
        end else if (cfg_wr) begin
            r_master_vol <= pwdata[3:0];
        end
    end

    // input item
    assign item.func          = i_in.func;
    assign item.kind          = i_in.kind;
    assign item.channel       = i_in.channel;
    assign item.param_first   = i_in.param_first;
    assign item.param_second  = i_in.param_second;
    assign item.data_byte     = i_in.data_byte;
    assign item.sysex_end     = i_in.sysex_end;
    assign item.clear_volumes = i_in.clear_volumes;
    assign i_in.ready         = !seq_busy;
    assign accept             = i_in.valid && !seq_busy;

    mwe_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_accept  (accept),
        .o_busy    (seq_busy),
        .i_load_ok (load_ok),
        .o_beat    (beat),
        .o_req     (vol_req),
        .o_wr      (vol_wr),
        .o_clr     (vol_clr),
        .i_vol     (vol_val),
        .i_vol_rdy (vol_rdy),
        .o_take    (vol_take)
    );

    mwe_vol u_vol (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_master (r_master_vol),
        .i_wr     (vol_wr),
        .i_clr    (vol_clr),
        .i_req    (vol_req),
        .i_take   (vol_take),
        .o_vol    (vol_val),
        .o_rdy    (vol_rdy)
    );

    // output register
    assign load_ok = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_ok) begin
            r_out_valid <= beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && beat.valid) begin
            r_out_byte <= beat.wire_byte;
            r_out_last <= beat.last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.wire_byte = r_out_byte;
    assign o_out.last      = r_out_last;
endmodule

// ----- rtl/mwe_ram.sv -----
// generic single write port ram with registered read
module mwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mwe_vol.sv -----
// channel volume store and master volume scaler pipeline
module mwe_vol (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [3:0]                i_master,
    input  mwe_pkg::t_vol_wr          i_wr,
    input  logic                      i_clr,
    input  mwe_pkg::t_vol_req         i_req,
    input  logic                      i_take,
    output logic [mwe_pkg::VOL_W-1:0] o_vol,
    output logic                      o_rdy
);
    import mwe_pkg::*;

    localparam int DEPTH = 1 << CH_W;

    logic [DEPTH-1:0]  r_vld;
    logic [VOL_W-1:0]  ram_rdata;
    logic              r_s1_vld;
    logic              r_s1_direct;
    logic              r_s1_unset;
    logic [VOL_W-1:0]  r_s1_dval;
    logic              r_s2_vld;
    logic [PROD_W-1:0] r_prod;
    logic              r_rdy;
    logic [VOL_W-1:0]  r_vol;
    logic [VOL_W-1:0]  s1_sv;
    logic [24:0]       s2_mul;
    logic [8:0]        s2_quo;
    logic [VOL_W-1:0]  s2_vol;

    mwe_ram #(
        .WIDTH (VOL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.ch),
        .i_wdata (i_wr.value),
        .i_re    (i_req.en && !i_req.direct),
        .i_raddr (i_req.ch),
        .o_rdata (ram_rdata)
    );

    // per channel written flags, cleared entries read as unset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.ch] <= 1'b1;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_rdy    <= 1'b0;
        end else begin
            r_s1_vld <= i_req.en;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld) begin
                r_rdy <= 1'b1;
            end else if (i_take) begin
                r_rdy <= 1'b0;
            end
        end
    end

    // song volume select: direct value, default when unset, or stored
    assign s1_sv = r_s1_direct ? r_s1_dval : (r_s1_unset ? VOL_DEFAULT : ram_rdata);

    // divide by 15 via reciprocal, exact for the product range
    assign s2_mul = 25'({1'b0, r_prod} + 12'd1) * 25'(DIV15_RECIP);
    assign s2_quo = s2_mul[24:16];
    assign s2_vol = (s2_quo > 9'(VOL_MAX)) ? VOL_MAX : s2_quo[VOL_W-1:0];

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_s1_direct <= i_req.direct;
            r_s1_unset  <= !r_vld[i_req.ch];
            r_s1_dval   <= i_req.value;
        end
        if (r_s1_vld) begin
            r_prod <= {4'b0, s1_sv} * {7'b0, i_master};
        end
        if (r_s2_vld) begin
            r_vol <= s2_vol;
        end
    end

    assign o_vol = r_vol;
    assign o_rdy = r_rdy;
endmodule

// ----- rtl/mwe_seq.sv -----
// item decoder and wire byte sequencer
module mwe_seq #(
    parameter int CHANNELS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mwe_pkg::t_item            i_item,
    input  logic                      i_accept,
    output logic                      o_busy,
    input  logic                      i_load_ok,
    output mwe_pkg::t_beat            o_beat,
    output mwe_pkg::t_vol_req         o_req,
    output mwe_pkg::t_vol_wr          o_wr,
    output logic                      o_clr,
    input  logic [mwe_pkg::VOL_W-1:0] i_vol,
    input  logic                      i_vol_rdy,
    output logic                      o_take
);
    import mwe_pkg::*;

    // sequencer modes
    localparam logic [1:0] M_MSG = 2'd0;
    localparam logic [1:0] M_CC  = 2'd1;
    localparam logic [1:0] M_VOL = 2'd2;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic            r_busy;
    logic [1:0]      r_step;
    logic [1:0]      r_mode;
    logic [1:0]      r_len;
    logic            r_bcast;
    logic [CH_W-1:0] r_ch;
    logic [7:0]      r_b0;
    logic [7:0]      r_b1;
    logic [7:0]      r_b2;

    logic            a_start;
    logic [1:0]      a_mode;
    logic [1:0]      a_len;
    logic            a_bcast;
    logic [CH_W-1:0] a_ch;
    logic [7:0]      a_b0;
    logic [7:0]      a_b1;
    logic [7:0]      a_b2;
    logic            a_vol;
    logic            a_rd;

    logic            grp_end;
    logic            last_grp;
    logic            vol_wait;
    logic            emit;
    logic [7:0]      out_byte;

    // decode of an incoming item
    always_comb begin
        a_start = 1'b0;
        a_mode  = M_MSG;
        a_len   = 2'd1;
        a_bcast = 1'b0;
        a_ch    = i_item.channel;
        a_b0    = i_item.data_byte;
        a_b1    = SYSEX_EOX;
        a_b2    = '0;
        a_vol   = 1'b0;
        a_rd    = 1'b0;
        case (i_item.func)
            FN_CHAN: begin
                if (i_item.kind != KD_IGNORED) begin
                    a_start = 1'b1;
                    if (i_item.kind == KD_CONTROL && i_item.param_first == CC_VOLUME) begin
                        a_mode = M_VOL;
                        a_b1   = {1'b0, CC_VOLUME};
                        a_len  = 2'd3;
                        a_vol  = 1'b1;
                    end else begin
                        a_b0 = {1'b1, i_item.kind, i_item.channel};
                        a_b1 = {1'b0, i_item.param_first};
                        a_b2 = {1'b0, i_item.param_second};
                        a_len = (i_item.kind == KD_PROGRAM || i_item.kind == KD_CHAN_PRESS)
                                ? 2'd2 : 2'd3;
                    end
                end
            end
            FN_SX_STATUS: begin
                a_start = 1'b1;
                a_len   = i_item.sysex_end ? 2'd2 : 2'd1;
            end
            FN_SX_BODY: begin
                a_start = 1'b1;
                a_len   = (i_item.sysex_end && i_item.data_byte != SYSEX_EOX) ? 2'd2 : 2'd1;
            end
            FN_NOTES_OFF: begin
                a_start = 1'b1;
                a_mode  = M_CC;
                a_b1    = {1'b0, CC_NOTES_OFF};
                a_len   = 2'd3;
                a_bcast = 1'b1;
                a_ch    = '0;
            end
            FN_RESET_CTRL: begin
                a_start = 1'b1;
                a_mode  = M_CC;
                a_b1    = {1'b0, CC_RESET_CTRL};
                a_len   = 2'd3;
                a_bcast = 1'b1;
                a_ch    = '0;
            end
            FN_REAPPLY: begin
                a_start = 1'b1;
                a_mode  = M_VOL;
                a_b1    = {1'b0, CC_VOLUME};
                a_len   = 2'd3;
                a_bcast = 1'b1;
                a_ch    = '0;
                a_rd    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // group and emit control
    assign grp_end  = (r_step == r_len - 2'd1);
    assign last_grp = !r_bcast || (r_ch == LAST_CH);
    assign vol_wait = (r_mode == M_VOL) && (r_step == 2'd2) && !i_vol_rdy;
    assign emit     = r_busy && i_load_ok && !vol_wait;

    // byte select by position in the group
    always_comb begin
        case (r_step)
            2'd0:    out_byte = (r_mode == M_MSG) ? r_b0 : {ST_CONTROL, r_ch};
            2'd1:    out_byte = r_b1;
            2'd2:    out_byte = (r_mode == M_VOL) ? {1'b0, i_vol} : r_b2;
            default: out_byte = r_b2;
        endcase
    end

    assign o_beat.valid     = emit;
    assign o_beat.wire_byte = out_byte;
    assign o_beat.last      = grp_end && last_grp;
    assign o_take           = emit && (r_mode == M_VOL) && (r_step == 2'd2);

    // volume requests: on accept of a volume item, and at each volume broadcast group boundary
    assign o_req.en     = (i_accept && (a_vol || a_rd))
                          || (emit && grp_end && !last_grp && r_mode == M_VOL);
    assign o_req.direct = i_accept && a_vol;
    assign o_req.ch     = i_accept ? a_ch : r_ch + CH_W'(1);
    assign o_req.value  = i_item.param_second;

    // store write and clear
    assign o_wr.en    = i_accept && a_vol;
    assign o_wr.ch    = i_item.channel;
    assign o_wr.value = i_item.param_second;
    assign o_clr      = i_accept && (i_item.func == FN_RESET_CTRL) && i_item.clear_volumes;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (i_accept && a_start) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (emit) begin
            if (grp_end) begin
                r_step <= 2'd0;
                if (last_grp) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    // item payload and broadcast channel counter
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode  <= a_mode;
            r_len   <= a_len;
            r_bcast <= a_bcast;
            r_ch    <= a_ch;
            r_b0    <= a_b0;
            r_b1    <= a_b1;
            r_b2    <= a_b2;
        end else if (emit && grp_end && !last_grp) begin
            r_ch <= r_ch + CH_W'(1);
        end
    end

    assign o_busy = r_busy;
endmodule

// ----- rtl/mwe_chk.sv -----
// port level checks of the midi wire encoder, bound to the top level
module mwe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_pready
);
    // a stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output byte changed while stalled");

    // the block only goes busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid))
        else $error("input ready dropped without an accepted item");

    // no output byte right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid after reset");

    // the configuration port never waits
    a_pready: assert property (@(posedge i_clk)
        i_pready)
        else $error("pready low");
endmodule

bind midi_wire_encoder_volume_scaled_top mwe_chk u_mwe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.wire_byte),
    .i_out_last  (o_out.last),
    .i_pready    (pready)
);
